>>> design/ccc_pkg.sv
// Types and constants for the calendar clock counter.
// Shared by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccc_pkg;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_REBASE = 2'd2;

  localparam logic [15:0] RESET_YEAR   = 16'd2026;
  localparam logic [3:0]  RESET_MONTH  = 4'd3;
  localparam logic [4:0]  RESET_DAY    = 5'd10;
  localparam logic [4:0]  RESET_HOUR   = 5'd23;
  localparam logic [5:0]  RESET_MINUTE = 6'd7;
  localparam logic [5:0]  RESET_SECOND = 6'd30;

  // Last value before a counter wraps (to zero, or to one for the month).
  localparam logic [5:0] SECOND_LAST = 6'd59;
  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [3:0] MONTH_LAST  = 4'd12;

  // Divisibility by 25 on 16 bits: multiply by the inverse of 25 modulo 2^16
  // and the product falls at or below 65535 / 25 exactly for multiples.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] MULT25_MAX = 16'd2621;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [15:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } req_t;

  typedef struct packed {
    logic [15:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic rebase;
    logic tick;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       due;
    logic       rsp_free;
  } ctrl_status_t;

  // Month length; months outside 1 to 12 count as 31 days.
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month) inside
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> design/ccc_ctrl.sv
// Sequencing state machine of the calendar clock counter.
// Drives the datapath through ccc_pkg::ctrl_cmd_t; depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_ready,
  input  wire ccc_pkg::ctrl_status_t status,
  output ccc_pkg::ctrl_cmd_t         ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.cmd)
          ccc_pkg::CMD_LOAD: begin
            ctrl.load  = 1'b1;
            state_next = ST_PUSH;
          end
          ccc_pkg::CMD_REBASE: begin
            ctrl.rebase = 1'b1;
            state_next  = ST_PUSH;
          end
          ccc_pkg::CMD_UPDATE: begin
            state_next = ST_STEP;
          end
          default: begin
            state_next = ST_PUSH;
          end
        endcase
      end
      ST_STEP: begin
        // advance one second per cycle until the base catches up
        if (status.due) begin
          ctrl.tick = 1'b1;
        end else begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.rsp_free) begin
          ctrl.publish = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/ccc_datapath.sv
// Calendar counters, base stamp and result register of the clock counter.
// Acts on ccc_pkg::ctrl_cmd_t from ccc_ctrl; depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_datapath #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ccc_pkg::req_t         req,
  input  wire ccc_pkg::ctrl_cmd_t    ctrl,
  output ccc_pkg::ctrl_status_t      status,
  output logic                       rsp_valid,
  input  wire logic                  rsp_ready,
  output ccc_pkg::rsp_t              rsp
);

  localparam logic [31:0] MsStep = 32'(MS_PER_SECOND);

  ccc_pkg::req_t req_q;

  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [31:0] base;
  logic        leap;

  logic [15:0] year_next;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic [4:0]  hour_next;
  logic [5:0]  minute_next;
  logic [5:0]  second_next;

  logic [31:0] diff;
  logic [15:0] year_x_inv;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        sec_wrap;
  logic        min_wrap;
  logic        hour_wrap;
  logic        day_wrap;
  logic        month_wrap;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      req_q <= req;
    end
  end

  assign diff = req_q.now_ms - base;

  // Leap flag is a register on the year; it settles before any month end.
  assign year_x_inv = year * ccc_pkg::INV25;
  assign div4       = (year[1:0] == 2'd0);
  assign div16      = (year[3:0] == 4'd0);
  assign div25      = (year_x_inv <= ccc_pkg::MULT25_MAX);

  always_ff @(posedge clk) begin
    leap <= (div4 && !div25) || (div16 && div25);
  end

  // One-second carry chain; values at or past their limit wrap as well.
  always_comb begin
    sec_wrap   = (second >= ccc_pkg::SECOND_LAST);
    min_wrap   = sec_wrap && (minute >= ccc_pkg::MINUTE_LAST);
    hour_wrap  = min_wrap && (hour >= ccc_pkg::HOUR_LAST);
    day_wrap   = hour_wrap && (day >= ccc_pkg::days_in(month, leap));
    month_wrap = day_wrap && (month >= ccc_pkg::MONTH_LAST);

    second_next = sec_wrap ? 6'd0 : second + 6'd1;
    minute_next = minute;
    hour_next   = hour;
    day_next    = day;
    month_next  = month;
    year_next   = year;
    if (sec_wrap) begin
      minute_next = min_wrap ? 6'd0 : minute + 6'd1;
    end
    if (min_wrap) begin
      hour_next = hour_wrap ? 5'd0 : hour + 5'd1;
    end
    if (hour_wrap) begin
      day_next = day_wrap ? 5'd1 : day + 5'd1;
    end
    if (day_wrap) begin
      month_next = month_wrap ? 4'd1 : month + 4'd1;
    end
    if (month_wrap) begin
      year_next = year + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year   <= ccc_pkg::RESET_YEAR;
      month  <= ccc_pkg::RESET_MONTH;
      day    <= ccc_pkg::RESET_DAY;
      hour   <= ccc_pkg::RESET_HOUR;
      minute <= ccc_pkg::RESET_MINUTE;
      second <= ccc_pkg::RESET_SECOND;
      base   <= '0;
    end else if (ctrl.load) begin
      year   <= req_q.set_year;
      month  <= req_q.set_month;
      day    <= req_q.set_day;
      hour   <= req_q.set_hour;
      minute <= req_q.set_minute;
      second <= req_q.set_second;
      base   <= req_q.now_ms;
    end else if (ctrl.rebase) begin
      base <= req_q.now_ms;
    end else if (ctrl.tick) begin
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      base   <= base + MsStep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.publish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.publish) begin
      rsp.cur_year   <= year;
      rsp.cur_month  <= month;
      rsp.cur_day    <= day;
      rsp.cur_hour   <= hour;
      rsp.cur_minute <= minute;
      rsp.cur_second <= second;
    end
  end

  assign status.cmd      = req_q.cmd;
  assign status.due      = (diff >= MsStep);
  assign status.rsp_free = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

>>> design/calendar_clock_counter.sv
// Gregorian calendar clock counter: a state machine (ccc_ctrl) sequences a
// datapath (ccc_datapath) that holds the calendar time and base stamp.
// Depends on ccc_pkg.
//
// One request is taken at a time. A load or rebase is captured, executed and
// published to the result register; an update that catches up n whole seconds
// steps between execute and publish: the calendar counters advance by one
// second per cycle, with the carry through minutes, hours, days, months and
// years settled in that same cycle, so the catch-up length sets the latency.
// The result sits in an output register; the next request is accepted while
// it waits, and a finished result waits only for the previous one to go.
`timescale 1ns / 1ps
`default_nettype none

module calendar_clock_counter #(
  parameter int unsigned MS_PER_SECOND = 1000
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ccc_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output ccc_pkg::rsp_t      rsp
);

  ccc_pkg::ctrl_cmd_t    ctrl;
  ccc_pkg::ctrl_status_t status;

  ccc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  ccc_datapath #(
    .MS_PER_SECOND (MS_PER_SECOND)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> design/ccc_checker.sv
// Port-level checks for calendar_clock_counter, bound to the top level.
// Depends on ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccc_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire ccc_pkg::req_t req,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire ccc_pkg::rsp_t rsp
);

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // One transaction in flight: no request accepted in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // A load with an empty output returns the loaded year, month and second.
  a_load_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && !rsp_valid && (req.cmd == ccc_pkg::CMD_LOAD)
    |-> ##3 rsp_valid && (rsp.cur_year == $past(req.set_year, 3))
        && (rsp.cur_second == $past(req.set_second, 3))
        && (rsp.cur_month == $past(req.set_month, 3)))
    else $error("load result wrong or late");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind calendar_clock_counter ccc_checker u_ccc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire

>>> dv/tb_calendar_clock_counter.sv
// Self-checking testbench for calendar_clock_counter: directed calendar edge cases,
// then random load, rebase and update traffic, under random stalls on both channels.
// Depends on ccc_pkg and the calendar_clock_counter RTL.
`timescale 1ns / 1ps

module tb_calendar_clock_counter;
  import ccc_pkg::*;

  localparam int unsigned MS_PER_SEC  = 1000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          RAND_ITEMS  = 1800;
  localparam int          QUIET_ITEMS = 150;
  localparam int          HOLD_AT_A   = 400;
  localparam int          HOLD_AT_B   = 1200;
  localparam int          HOLD_CYCLES = 100;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LIMIT       = 1500000;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] base_ms;
  } cal_time_t;

  typedef struct packed {
    req_t req;
    logic drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  stim_t       pending_req_q[$];
  rsp_t        expected_time_q[$];
  cal_time_t   cal_now;
  logic [31:0] gen_base = '0;
  logic        drain_next = 1'b0;
  int          stim_total = 0;
  int          reqs_sent = 0;
  int          times_seen = 0;
  int          err_cnt = 0;
  int          cycles = 0;
  int          idle_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          hold_idx = 0;
  logic        quiet;

  assign quiet = (reqs_sent + QUIET_ITEMS >= stim_total);

  calendar_clock_counter #(.MS_PER_SECOND(MS_PER_SEC)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic year_has_feb29(logic [15:0] y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [4:0] month_length(logic [15:0] y, logic [3:0] m);
    case (m)
      4'd2:                    return year_has_feb29(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default:                 return 5'd31;
    endcase
  endfunction

  // One second of advance; fields past their range wrap on their first increment.
  function automatic cal_time_t step_one_second(cal_time_t t);
    if (t.second < 6'd59) begin
      t.second = t.second + 6'd1;
    end else begin
      t.second = '0;
      if (t.minute < 6'd59) begin
        t.minute = t.minute + 6'd1;
      end else begin
        t.minute = '0;
        if (t.hour < 5'd23) begin
          t.hour = t.hour + 5'd1;
        end else begin
          t.hour = '0;
          if (t.day < month_length(t.year, t.month)) begin
            t.day = t.day + 5'd1;
          end else begin
            t.day = 5'd1;
            // month 0 steps to 1 without a year carry
            if (t.month < 4'd12) begin
              t.month = t.month + 4'd1;
            end else begin
              t.month = 4'd1;
              t.year  = t.year + 16'd1;
            end
          end
        end
      end
    end
    return t;
  endfunction

  function automatic cal_time_t apply_request(cal_time_t t, req_t r);
    logic [31:0] diff;
    int unsigned secs;
    case (r.cmd)
      CMD_UPDATE: begin
        diff = r.now_ms - t.base_ms;
        secs = diff / MS_PER_SEC;
        t.base_ms = t.base_ms + secs * MS_PER_SEC;
        repeat (secs) t = step_one_second(t);
      end
      CMD_LOAD: begin
        t.year    = r.set_year;
        t.month   = r.set_month;
        t.day     = r.set_day;
        t.hour    = r.set_hour;
        t.minute  = r.set_minute;
        t.second  = r.set_second;
        t.base_ms = r.now_ms;
      end
      CMD_REBASE: t.base_ms = r.now_ms;
      default: ;
    endcase
    return t;
  endfunction

  // Track the base stamp while queueing so that updates can be placed a given
  // number of milliseconds ahead of it.
  task automatic push_stim(req_t r);
    logic [31:0] diff;
    pending_req_q.push_back('{req: r, drain: drain_next});
    drain_next = 1'b0;
    case (r.cmd)
      CMD_UPDATE: begin
        diff = r.now_ms - gen_base;
        gen_base = gen_base + (diff / MS_PER_SEC) * MS_PER_SEC;
      end
      CMD_LOAD, CMD_REBASE: gen_base = r.now_ms;
      default: ;
    endcase
  endtask

  task automatic queue_cmd(logic [1:0] cmd, logic [31:0] now);
    req_t r;
    r.cmd        = cmd;
    r.now_ms     = now;
    r.set_year   = 16'($urandom);
    r.set_month  = 4'($urandom);
    r.set_day    = 5'($urandom);
    r.set_hour   = 5'($urandom);
    r.set_minute = 6'($urandom);
    r.set_second = 6'($urandom);
    push_stim(r);
  endtask

  task automatic queue_update(logic [31:0] delta);
    queue_cmd(CMD_UPDATE, gen_base + delta);
  endtask

  task automatic queue_load(logic [15:0] y, logic [3:0] mo, logic [4:0] d, logic [4:0] h,
                            logic [5:0] mi, logic [5:0] s, logic [31:0] now);
    req_t r;
    r = '{cmd: CMD_LOAD, now_ms: now, set_year: y, set_month: mo, set_day: d,
          set_hour: h, set_minute: mi, set_second: s};
    push_stim(r);
  endtask

  task automatic flag_error(string what, rsp_t want, rsp_t got);
    if (err_cnt < 10)
      $display("%0t %s: expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
               $realtime, what, want.cur_year, want.cur_month, want.cur_day,
               want.cur_hour, want.cur_minute, want.cur_second, got.cur_year,
               got.cur_month, got.cur_day, got.cur_hour, got.cur_minute, got.cur_second);
    err_cnt++;
  endtask

  // Driver: predict on acceptance, then offer the next transaction or idle.
  always @(posedge clk) begin
    logic  take;
    stim_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
      idle_left = 0;
      cal_now = '{year: RESET_YEAR, month: RESET_MONTH, day: RESET_DAY, hour: RESET_HOUR,
                  minute: RESET_MINUTE, second: RESET_SECOND, base_ms: '0};
    end else begin
      take = req_valid && req_ready;
      if (take) begin
        cal_now = apply_request(cal_now, req);
        expected_time_q.push_back('{cur_year: cal_now.year, cur_month: cal_now.month,
                                    cur_day: cal_now.day, cur_hour: cal_now.hour,
                                    cur_minute: cal_now.minute,
                                    cur_second: cal_now.second});
        reqs_sent <= reqs_sent + 1;
        if (!quiet && $urandom_range(0, 5) == 0)
          idle_left = $urandom_range(1, 3);
      end
      if (!req_valid || take) begin
        if (idle_left > 0) begin
          idle_left--;
          req_valid <= 1'b0;
        end else if (pending_req_q.size() > 0 &&
                     (!pending_req_q[0].drain || reqs_sent + take == times_seen)) begin
          nxt = pending_req_q.pop_front();
          req       <= nxt.req;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Result side ready: random short stalls plus two long hold-offs.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if ((hold_idx == 0 && times_seen >= HOLD_AT_A) ||
                 (hold_idx == 1 && times_seen >= HOLD_AT_B)) begin
      hold_left = HOLD_CYCLES - 1;
      hold_idx++;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Monitor: compare each result transaction with the oldest expected time.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      times_seen <= times_seen + 1;
      if (expected_time_q.size() == 0) begin
        flag_error("unexpected result", '0, rsp);
      end else begin
        want = expected_time_q.pop_front();
        if (rsp.cur_year !== want.cur_year || rsp.cur_month !== want.cur_month ||
            rsp.cur_day !== want.cur_day || rsp.cur_hour !== want.cur_hour ||
            rsp.cur_minute !== want.cur_minute || rsp.cur_second !== want.cur_second)
          flag_error("mismatch", want, rsp);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_calendar_clock_counter: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] delta;
    logic [15:0] yr;
    int sel;
    int pick;

    // Directed: reset time, timestamp wrap, year wrap, leap rules, odd loads.
    queue_update(32'd0);
    queue_update(32'd2999);
    queue_cmd(CMD_UNUSED, 32'h5A5A_5A5A);
    queue_cmd(CMD_REBASE, 32'hFFFF_FFFF);
    queue_update(32'd2999);
    queue_load(16'd65535, 4'd12, 5'd31, 5'd23, 6'd59, 6'd58, 32'd1000);
    queue_update(32'd3500);
    queue_load(16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'h8000_0000);
    queue_update(32'd1000);
    queue_load(16'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 32'h7FFF_FFFF);
    queue_update(32'd1000);
    queue_load(16'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59, 32'd12345);
    queue_update(32'd1999);
    queue_load(16'h1234, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59, 32'd0);
    queue_update(32'd1000);
    queue_load(16'd2030, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59, 32'h0000_FFFF);
    queue_update(32'd1000);
    queue_load(16'd2030, 4'd4, 5'd0, 5'd31, 6'd63, 6'd63, 32'h1357_9BDF);
    queue_update(32'd1000);
    queue_load(16'hFFFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
    queue_update(32'd999);
    queue_update(32'd1001);
    queue_load(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 32'd0);
    queue_update(32'd100000 * MS_PER_SEC);

    // Random: mostly short catch-ups, loads near month ends, some noise.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 900 || i == 1500)
        drain_next = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          delta = $urandom_range(0, 5000);
        else if (pick < 97)
          delta = $urandom_range(0, 60000);
        else
          delta = $urandom_range(0, 3000000);
        queue_update(delta);
      end else if (sel < 70) begin
        case ($urandom_range(0, 3))
          0:       yr = 16'($urandom);
          1:       yr = 16'($urandom_range(0, 655) * 100);
          2:       yr = 16'($urandom_range(0, 16383) * 4);
          default: yr = 16'hFFFF;
        endcase
        if ($urandom_range(0, 2) != 0)
          queue_load(yr, 4'($urandom_range(1, 12)), 5'($urandom_range(27, 31)), 5'd23,
                     6'd59, 6'($urandom_range(55, 59)), $urandom);
        else
          queue_load(yr, 4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom),
                     6'($urandom), $urandom);
      end else if (sel < 85) begin
        queue_cmd(CMD_REBASE, $urandom);
      end else begin
        queue_cmd(CMD_UNUSED, $urandom);
      end
    end
    stim_total = pending_req_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (reqs_sent == stim_total);
    wait (times_seen == reqs_sent);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_time_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_time_q.size());
      err_cnt += expected_time_q.size();
    end
    if (err_cnt == 0)
      $display("tb_calendar_clock_counter: clean");
    else
      $display("tb_calendar_clock_counter: errors");
    $finish;
  end

endmodule

>>> calendar_clock_counter.f
design/ccc_pkg.sv
design/ccc_ctrl.sv
design/ccc_datapath.sv
design/calendar_clock_counter.sv
design/ccc_checker.sv
dv/tb_calendar_clock_counter.sv
